[rtl/fwh_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fwh_pkg: shared types and codes
// Request modes, result outcomes, controller states and the command bundle
// that the controller sends to the datapath.
// ----------------------------------------------------------------------------
package fwh_pkg;

	localparam int MODE_W = 2;
	localparam int OUTCOME_W = 3;
	localparam int REQ_W = 4;
	localparam int SERVED_W = 32;

	localparam logic [MODE_W-1:0] MODE_ENQ = 2'd0;
	localparam logic [MODE_W-1:0] MODE_BDEQ = 2'd1;

	localparam logic [OUTCOME_W-1:0] OUT_STORED = 3'd0;
	localparam logic [OUTCOME_W-1:0] OUT_DELIVERED = 3'd1;
	localparam logic [OUTCOME_W-1:0] OUT_PARKED = 3'd2;
	localparam logic [OUTCOME_W-1:0] OUT_TRY_EMPTY = 3'd3;
	localparam logic [OUTCOME_W-1:0] OUT_FULL_DROP = 3'd4;
	localparam logic [OUTCOME_W-1:0] OUT_WAIT_REFUSED = 3'd5;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} fwh_state_t;

	typedef struct packed {
		logic capture;
		logic exec;
	} fwh_cmd_t;

endpackage

`default_nettype wire

[rtl/fwh_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fwh_ctrl: request sequencer
// Takes a request when the result register is free, has the datapath
// execute it and holds the result valid until it is taken.
// ----------------------------------------------------------------------------
module fwh_ctrl
	import fwh_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  wire logic     out_ready,
	output fwh_cmd_t      cmd
);

	fwh_state_t state_q;
	fwh_state_t state_nxt;
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		in_ready = 1'b0;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				// A new request may enter in the cycle the old result leaves.
				in_ready = !out_valid_q || out_ready;
				if (in_valid && in_ready) begin
					cmd.capture = 1'b1;
					state_nxt = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

[rtl/fwh_dpath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fwh_dpath: word and waiter queues
// Holds the word memory, the waiter memory, their pointers and fill counts,
// the served counter and the result register.
// ----------------------------------------------------------------------------
module fwh_dpath
	import fwh_pkg::*;
#(
	parameter int WORD_DEPTH = 256,
	parameter int WAITER_DEPTH = 16,
	parameter int WORD_WIDTH = 32,
	localparam int WPTR_W = $clog2(WORD_DEPTH),
	localparam int WCNT_W = $clog2(WORD_DEPTH + 1),
	localparam int QPTR_W = $clog2(WAITER_DEPTH),
	localparam int QCNT_W = $clog2(WAITER_DEPTH + 1)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire fwh_cmd_t              cmd,
	input  wire logic [MODE_W-1:0]     mode,
	input  wire logic [WORD_WIDTH-1:0] item,
	input  wire logic [REQ_W-1:0]      requester,
	output logic [OUTCOME_W-1:0]       outcome,
	output logic [REQ_W-1:0]           target,
	output logic [WORD_WIDTH-1:0]      word,
	output logic [WCNT_W-1:0]          stored_count,
	output logic [QCNT_W-1:0]          waiter_count,
	output logic [SERVED_W-1:0]        served_count
);

	logic [WORD_WIDTH-1:0] word_mem_q [WORD_DEPTH];
	logic [REQ_W-1:0]      wait_mem_q [WAITER_DEPTH];
	logic [WORD_WIDTH-1:0] word_rd_q;
	logic [REQ_W-1:0]      wait_rd_q;

	logic [WPTR_W-1:0] word_head_q, word_tail_q;
	logic [WCNT_W-1:0] word_fill_q, word_fill_nxt;
	logic [QPTR_W-1:0] wait_head_q, wait_tail_q;
	logic [QCNT_W-1:0] wait_fill_q, wait_fill_nxt;
	logic [SERVED_W-1:0] served_q, served_nxt;

	logic [MODE_W-1:0]     mode_q;
	logic [WORD_WIDTH-1:0] item_q;
	logic [REQ_W-1:0]      req_q;

	logic [OUTCOME_W-1:0]  outcome_q, res_outcome;
	logic [REQ_W-1:0]      target_q, res_target;
	logic [WORD_WIDTH-1:0] word_q, res_word;
	logic [WCNT_W-1:0]     stored_q;
	logic [QCNT_W-1:0]     waiters_q;

	logic word_push, word_pop, wait_push, wait_pop;

	// Memories and the request/result registers carry no reset.
	always_ff @(posedge clk) begin
		word_rd_q <= word_mem_q[word_head_q];
		wait_rd_q <= wait_mem_q[wait_head_q];
		if (cmd.exec && word_push) begin
			word_mem_q[word_tail_q] <= item_q;
		end
		if (cmd.exec && wait_push) begin
			wait_mem_q[wait_tail_q] <= req_q;
		end
		if (cmd.capture) begin
			mode_q <= mode;
			item_q <= item;
			req_q <= requester;
		end
		if (cmd.exec) begin
			outcome_q <= res_outcome;
			target_q <= res_target;
			word_q <= res_word;
			stored_q <= word_fill_nxt;
			waiters_q <= wait_fill_nxt;
		end
	end

	// Decide the request against the head entries read during capture.
	always_comb begin
		word_push = 1'b0;
		word_pop = 1'b0;
		wait_push = 1'b0;
		wait_pop = 1'b0;
		res_outcome = OUT_TRY_EMPTY;
		res_target = '0;
		res_word = '0;
		if (mode_q == MODE_ENQ) begin
			if (wait_fill_q != '0) begin
				wait_pop = 1'b1;
				res_target = wait_rd_q;
				res_word = item_q;
				res_outcome = OUT_DELIVERED;
			end else if (word_fill_q == WCNT_W'(WORD_DEPTH)) begin
				res_outcome = OUT_FULL_DROP;
			end else begin
				word_push = 1'b1;
				res_outcome = OUT_STORED;
			end
		end else if (word_fill_q != '0) begin
			word_pop = 1'b1;
			res_target = req_q;
			res_word = word_rd_q;
			res_outcome = OUT_DELIVERED;
		end else if (mode_q == MODE_BDEQ) begin
			if (wait_fill_q == QCNT_W'(WAITER_DEPTH)) begin
				res_outcome = OUT_WAIT_REFUSED;
			end else begin
				wait_push = 1'b1;
				res_outcome = OUT_PARKED;
			end
		end
		word_fill_nxt = word_fill_q;
		if (word_push) begin
			word_fill_nxt = word_fill_q + 1'b1;
		end else if (word_pop) begin
			word_fill_nxt = word_fill_q - 1'b1;
		end
		wait_fill_nxt = wait_fill_q;
		if (wait_push) begin
			wait_fill_nxt = wait_fill_q + 1'b1;
		end else if (wait_pop) begin
			wait_fill_nxt = wait_fill_q - 1'b1;
		end
		served_nxt = (word_pop || wait_pop) ? served_q + 1'b1 : served_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_head_q <= '0;
			word_tail_q <= '0;
			word_fill_q <= '0;
			wait_head_q <= '0;
			wait_tail_q <= '0;
			wait_fill_q <= '0;
			served_q <= '0;
		end else if (cmd.exec) begin
			word_fill_q <= word_fill_nxt;
			wait_fill_q <= wait_fill_nxt;
			served_q <= served_nxt;
			if (word_push) begin
				word_tail_q <= (word_tail_q == WPTR_W'(WORD_DEPTH - 1)) ? '0
					: word_tail_q + 1'b1;
			end
			if (word_pop) begin
				word_head_q <= (word_head_q == WPTR_W'(WORD_DEPTH - 1)) ? '0
					: word_head_q + 1'b1;
			end
			if (wait_push) begin
				wait_tail_q <= (wait_tail_q == QPTR_W'(WAITER_DEPTH - 1)) ? '0
					: wait_tail_q + 1'b1;
			end
			if (wait_pop) begin
				wait_head_q <= (wait_head_q == QPTR_W'(WAITER_DEPTH - 1)) ? '0
					: wait_head_q + 1'b1;
			end
		end
	end

	assign outcome = outcome_q;
	assign target = target_q;
	assign word = word_q;
	assign stored_count = stored_q;
	assign waiter_count = waiters_q;
	// The served counter only moves on execute, so it matches the held result.
	assign served_count = served_q;

endmodule

`default_nettype wire

[rtl/fifo_with_waiter_handoff_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fifo_with_waiter_handoff_core: word FIFO with hand-off to parked requesters
// Enqueues serve the oldest parked requester first, blocking dequeues park
// when no word is stored, try dequeues report empty.
//
//   channel  handshake            payload
//   in       in_valid / in_ready  mode, item, requester
//   out      out_valid/ out_ready outcome, target, word, stored_count,
//                                 waiter_count, served_count
//
// Each request is first captured, while both memories read their head
// entries, and then executed. A request is taken in the cycle its
// predecessor's result leaves, but never while the predecessor still executes.
// A stalled result holds off the next request.
// Reset clears the pointers, fill counts and the served counter; memory
// contents need no clearing since the fill counts guard every read.
// ----------------------------------------------------------------------------
module fifo_with_waiter_handoff_core
	import fwh_pkg::*;
#(
	parameter int WORD_DEPTH = 256,
	parameter int WAITER_DEPTH = 16,
	parameter int WORD_WIDTH = 32,
	localparam int WCNT_W = $clog2(WORD_DEPTH + 1),
	localparam int QCNT_W = $clog2(WAITER_DEPTH + 1)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [MODE_W-1:0]     mode,
	input  wire logic [WORD_WIDTH-1:0] item,
	input  wire logic [REQ_W-1:0]      requester,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [OUTCOME_W-1:0]       outcome,
	output logic [REQ_W-1:0]           target,
	output logic [WORD_WIDTH-1:0]      word,
	output logic [WCNT_W-1:0]          stored_count,
	output logic [QCNT_W-1:0]          waiter_count,
	output logic [SERVED_W-1:0]        served_count
);

	fwh_cmd_t cmd;

	fwh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	fwh_dpath #(
		.WORD_DEPTH   (WORD_DEPTH),
		.WAITER_DEPTH (WAITER_DEPTH),
		.WORD_WIDTH   (WORD_WIDTH)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.mode         (mode),
		.item         (item),
		.requester    (requester),
		.outcome      (outcome),
		.target       (target),
		.word         (word),
		.stored_count (stored_count),
		.waiter_count (waiter_count),
		.served_count (served_count)
	);

	// A request is never taken while an untaken result is held.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |-> (!out_valid || out_ready))
		else $error("request accepted over a held result");

	// Every accepted request yields its result after the execute cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (!out_valid ##1 out_valid))
		else $error("result did not follow the request");

	// Only a delivery carries a word and a target.
	a_quiet_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && outcome != OUT_DELIVERED) |-> (word == '0 && target == '0))
		else $error("payload set without a delivery");

	// Fill counts stay within the queue depths.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (stored_count <= WCNT_W'(WORD_DEPTH)
			&& waiter_count <= QCNT_W'(WAITER_DEPTH)))
		else $error("fill count beyond depth");

endmodule

`default_nettype wire
